FILE: hw/rtl/vfd_pkg.sv
// ----------------------------------------------------------------------------
// vfd_pkg: shared types and constants for the velocity frame deframer
// Byte and frame types, register codes and reset defaults.
// ----------------------------------------------------------------------------
package vfd_pkg;

    localparam int FRAME_LEN = 8;
    localparam int CNT_W     = $clog2(FRAME_LEN);
    localparam int CFG_IDX_W = 2;

    typedef logic [7:0]       t_byte;
    typedef logic [CNT_W-1:0] t_count;

    // last slot of a frame (trailer position)
    localparam t_count LAST_IDX = t_count'(FRAME_LEN - 1);

    // reset defaults of the configuration registers
    localparam t_byte HEADER_DEFAULT  = 8'hA0;
    localparam t_byte START_DEFAULT   = 8'h06;
    localparam t_byte TRAILER_DEFAULT = 8'hA1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER  = 2'd0,
        CFG_START   = 2'd1,
        CFG_TRAILER = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_byte header_byte;
        t_byte start_byte;
        t_byte trailer_byte;
    } t_cfg;

    typedef struct packed {
        logic [15:0] linear_x;
        logic [15:0] linear_y;
        logic [15:0] angular_z;
    } t_frame;

endpackage

FILE: hw/rtl/vfd_parser.sv
// ----------------------------------------------------------------------------
// vfd_parser: frame detection and byte storage
// Tracks header/start detection, counts stored bytes and flags a complete
// frame whose last byte matches the trailer.
// ----------------------------------------------------------------------------
module vfd_parser
    import vfd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_step,
    input  t_byte  i_byte,
    output logic   o_hit,
    output t_frame o_frame
);

    logic   r_header_seen;
    logic   r_storing;
    t_count r_count;
    t_byte  r_frame [1:6];   // only the payload bytes are ever read

    logic   n_header_seen;
    logic   n_storing;
    t_count n_count;
    logic   w_armed;
    logic   w_start;
    logic   w_store;
    logic   w_done;

    // detection and counter next state
    always_comb begin
        w_armed       = r_header_seen | (i_byte == i_cfg.header_byte);
        w_start       = w_armed & (i_byte == i_cfg.start_byte);
        n_header_seen = w_armed & ~w_start;
        w_store       = r_storing | w_start;
        w_done        = w_store & (r_count == LAST_IDX);
        n_storing     = w_store & ~w_done;
        n_count       = r_count;
        if (w_store) begin
            n_count = w_done ? '0 : r_count + t_count'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_seen <= 1'b0;
            r_storing     <= 1'b0;
            r_count       <= '0;
        end else if (i_step) begin
            r_header_seen <= n_header_seen;
            r_storing     <= n_storing;
            r_count       <= n_count;
        end
    end

    // payload byte store, slots 1..6
    always_ff @(posedge i_clk) begin
        if (i_step && w_store && r_count >= t_count'(1) && r_count <= t_count'(6)) begin
            r_frame[r_count] <= i_byte;
        end
    end

    // the current byte is the last one; compare it directly
    assign o_hit              = w_done & (i_byte == i_cfg.trailer_byte);
    assign o_frame.linear_x  = {r_frame[1], r_frame[2]};
    assign o_frame.linear_y  = {r_frame[3], r_frame[4]};
    assign o_frame.angular_z = {r_frame[5], r_frame[6]};

`ifndef SYNTH
    // a nonzero count only exists while a frame is being stored
    a_count_implies_storing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 |-> r_storing)
        else $error("byte count nonzero while not storing");

    // a hit only comes from the last slot of an active frame
    a_hit_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> (r_storing && r_count == LAST_IDX))
        else $error("frame hit outside the last slot");

    // a completed frame returns the counter to idle
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_hit) |=> (r_count == '0 && !r_storing))
        else $error("counter not cleared after frame end");
`endif

endmodule

FILE: hw/rtl/velocity_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// velocity_frame_deframer_top: serial velocity frame extractor
// Input register, frame parser and output register with valid/ready on both
// sides, plus the configuration register file.
// ----------------------------------------------------------------------------
// A frame's last byte reaches the output through the input register, then
//   the parser into the output register.
// Throughput: one byte per cycle; the input stalls only while the output
//   register holds an untaken result and the input register is full.
// Reset (synchronous, active low): clears flags, counter and valids and
//   loads the register defaults; the frame store is not cleared.
module velocity_frame_deframer_top
    import vfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    // byte input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_rx_byte,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [15:0]          o_linear_x,
    output logic [15:0]          o_linear_y,
    output logic [15:0]          o_angular_z
);

    t_cfg   r_cfg;
    logic   r_in_valid;
    t_byte  r_in_byte;
    logic   r_out_valid;
    t_frame r_out;

    logic   w_adv;
    logic   w_step;
    logic   w_hit;
    t_frame w_frame;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte  <= HEADER_DEFAULT;
            r_cfg.start_byte   <= START_DEFAULT;
            r_cfg.trailer_byte <= TRAILER_DEFAULT;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HEADER:  r_cfg.header_byte  <= i_cfg_data;
                CFG_START:   r_cfg.start_byte   <= i_cfg_data;
                CFG_TRAILER: r_cfg.trailer_byte <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // pipeline advance: output register free or being drained
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    vfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_hit   (w_hit),
        .o_frame (w_frame)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_step && w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_hit) begin
            r_out <= w_frame;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_linear_x  = r_out.linear_x;
    assign o_linear_y  = r_out.linear_y;
    assign o_angular_z = r_out.angular_z;

`ifndef SYNTH
    // a result beat waiting for the sink is never dropped
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result beat lost while stalled");

    // an accepted byte lands in the input register
    a_in_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted beat not registered");

    // the parser only steps when the output side has room
    a_step_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |-> (!r_out_valid || i_out_ready))
        else $error("parser stepped into a full output register");
`endif

endmodule
